/* sv/cthn_pkg.sv */
// Shared types and constants for the two-hop neighbourhood unit.
package cthn_pkg;

    localparam int MAX_VERTICES = 1024;
    localparam int MAX_EDGES    = 8192;

    localparam int VW  = $clog2(MAX_VERTICES);
    localparam int NVW = $clog2(MAX_VERTICES + 1);
    localparam int RW  = $clog2(MAX_VERTICES + 1);
    localparam int EW  = $clog2(MAX_EDGES + 1);
    localparam int CW  = $clog2(MAX_EDGES);

    localparam int REQ_W   = 2;
    localparam int INDEX_W = 13;
    localparam int VALUE_W = 14;
    localparam int QV_W    = 10;
    localparam int FV_W    = 10;
    localparam int FC_W    = 11;
    localparam int VC_W    = 11;

    localparam logic [VC_W-1:0] VC_RESET = 11'd1024;
    localparam logic            HOP_TWO_RESET = 1'b1;

    typedef enum logic [REQ_W-1:0] {
        REQ_ROW_WR = 2'd0,
        REQ_COL_WR = 2'd1,
        REQ_EXPAND = 2'd2,
        REQ_READ   = 2'd3
    } t_req;

    typedef enum logic {
        CFG_HOP_DEPTH    = 1'b0,
        CFG_VERTEX_COUNT = 1'b1
    } t_cfg_reg;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_READ,
        ST_CLR_RD,
        ST_CLR_WR,
        ST_ROW0,
        ST_ROW1,
        ST_ROW2,
        ST_COL,
        ST_NB,
        ST_NBW,
        ST_OUT,
        ST_OUTNB
    } t_state;

    typedef struct packed {
        logic row_we;
        logic col_we;
    } t_graph_ctl;

    typedef struct packed {
        logic vis_we;
        logic vis_set;
        logic fnd_we;
    } t_visit_ctl;

endpackage

/* sv/cthn_graph_mem.sv */
// Row-start and column memories holding the graph in CSR form.
module cthn_graph_mem import cthn_pkg::*; (
    input  logic          i_clk,
    input  t_graph_ctl    i_ctl,
    input  logic [RW-1:0] i_row_waddr,
    input  logic [EW-1:0] i_row_wdata,
    input  logic [RW-1:0] i_row_raddr,
    output logic [EW-1:0] o_row_rdata,
    input  logic [CW-1:0] i_col_waddr,
    input  logic [VW-1:0] i_col_wdata,
    input  logic [CW-1:0] i_col_raddr,
    output logic [VW-1:0] o_col_rdata
);

    logic [EW-1:0] r_row_mem [MAX_VERTICES + 1];
    logic [VW-1:0] r_col_mem [MAX_EDGES];
    logic [EW-1:0] r_row_q;
    logic [VW-1:0] r_col_q;

    always_ff @(posedge i_clk) begin
        if (i_ctl.row_we) begin
            r_row_mem[i_row_waddr] <= i_row_wdata;
        end
        r_row_q <= r_row_mem[i_row_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.col_we) begin
            r_col_mem[i_col_waddr] <= i_col_wdata;
        end
        r_col_q <= r_col_mem[i_col_raddr];
    end

    assign o_row_rdata = r_row_q;
    assign o_col_rdata = r_col_q;

endmodule

/* sv/cthn_visit_mem.sv */
// Visited bitmap and found-list memories.
module cthn_visit_mem import cthn_pkg::*; (
    input  logic          i_clk,
    input  t_visit_ctl    i_ctl,
    input  logic [VW-1:0] i_vis_raddr,
    input  logic [VW-1:0] i_vis_waddr,
    output logic          o_vis_rdata,
    input  logic [VW-1:0] i_fnd_raddr,
    input  logic [VW-1:0] i_fnd_waddr,
    input  logic [VW-1:0] i_fnd_wdata,
    output logic [VW-1:0] o_fnd_rdata
);

    logic          r_vis_mem [MAX_VERTICES];
    logic [VW-1:0] r_fnd_mem [MAX_VERTICES];
    logic          r_vis_q;
    logic [VW-1:0] r_fnd_q;

    always_ff @(posedge i_clk) begin
        if (i_ctl.vis_we) begin
            r_vis_mem[i_vis_waddr] <= i_ctl.vis_set;
        end
        r_vis_q <= r_vis_mem[i_vis_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.fnd_we) begin
            r_fnd_mem[i_fnd_waddr] <= i_fnd_wdata;
        end
        r_fnd_q <= r_fnd_mem[i_fnd_raddr];
    end

    assign o_vis_rdata = r_vis_q;
    assign o_fnd_rdata = r_fnd_q;

endmodule

/* sv/cthn_ctrl.sv */
// Request decode, expansion sequencer and result register.
module cthn_ctrl import cthn_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    output logic               o_busy,
    input  logic [REQ_W-1:0]   i_req_type,
    input  logic [INDEX_W-1:0] i_index,
    input  logic [VALUE_W-1:0] i_value,
    input  logic [QV_W-1:0]    i_query_vertex,
    input  logic               i_hop_two,
    input  logic [VC_W-1:0]    i_vertex_count,
    output logic               o_strobe,
    output logic               o_status,
    output logic [FV_W-1:0]    o_found_vertex,
    output logic [FC_W-1:0]    o_found_count,
    output t_graph_ctl         o_gctl,
    output logic [RW-1:0]      o_row_waddr,
    output logic [EW-1:0]      o_row_wdata,
    output logic [RW-1:0]      o_row_raddr,
    input  logic [EW-1:0]      i_row_rdata,
    output logic [CW-1:0]      o_col_waddr,
    output logic [VW-1:0]      o_col_wdata,
    output logic [CW-1:0]      o_col_raddr,
    input  logic [VW-1:0]      i_col_rdata,
    output t_visit_ctl         o_vctl,
    output logic [VW-1:0]      o_vis_raddr,
    output logic [VW-1:0]      o_vis_waddr,
    input  logic               i_vis_rdata,
    output logic [VW-1:0]      o_fnd_raddr,
    output logic [VW-1:0]      o_fnd_waddr,
    output logic [VW-1:0]      o_fnd_wdata,
    input  logic [VW-1:0]      i_fnd_rdata
);

    t_state          r_state, n_state;
    logic [NVW-1:0]  r_ci, n_ci;
    logic [NVW-1:0]  r_ft, n_ft;
    logic            r_strobe, n_strobe;
    logic            r_status, n_status;
    logic [FV_W-1:0] r_fv, n_fv;
    logic [VW-1:0]   r_v, n_v;
    logic [VW-1:0]   r_u, n_u;
    logic            r_level, n_level;
    logic [EW-1:0]   r_lo, n_lo;
    logic [EW-1:0]   r_hi, n_hi;
    logic [EW-1:0]   r_e, n_e;
    logic [EW-1:0]   r_oe, n_oe;
    logic [EW-1:0]   r_ohi, n_ohi;

    logic            accept;
    logic [NVW-1:0]  nv;
    logic            qv_ok;
    logic            row_ok;
    logic            col_ok;
    logic            rd_ok;
    logic            ft_room;
    logic            clr_last;
    logic            init_last;
    logic            nb_ok;
    logic            walk_end;
    logic            outer_end;

    assign accept    = i_start && (r_state == ST_IDLE);
    assign nv        = (32'(i_vertex_count) > 32'(MAX_VERTICES)) ? NVW'(MAX_VERTICES)
                                                                 : NVW'(i_vertex_count);
    assign qv_ok     = 32'(i_query_vertex) < 32'(nv);
    assign row_ok    = 32'(i_index) <= 32'(MAX_VERTICES);
    assign col_ok    = (32'(i_index) < 32'(MAX_EDGES)) && (32'(i_value) < 32'(MAX_VERTICES));
    assign rd_ok     = 32'(i_index) < 32'(r_ft);
    assign ft_room   = 32'(r_ft) < 32'(MAX_VERTICES);
    assign clr_last  = NVW'(r_ci + 1'b1) == r_ft;
    assign init_last = 32'(r_ci) == 32'(MAX_VERTICES - 1);
    assign nb_ok     = 32'(i_col_rdata) < 32'(nv);
    assign walk_end  = r_e == r_hi;
    assign outer_end = r_oe == r_ohi;

    // memory addressing
    assign o_row_waddr = RW'(i_index);
    assign o_row_wdata = (32'(i_value) > 32'(MAX_EDGES)) ? EW'(MAX_EDGES) : EW'(i_value);
    assign o_col_waddr = CW'(i_index);
    assign o_col_wdata = VW'(i_value);
    assign o_row_raddr = (r_state == ST_ROW1) ? RW'(r_v) + 1'b1 : RW'(r_v);
    assign o_col_raddr = (r_state == ST_OUT) ? r_oe[CW-1:0] : r_e[CW-1:0];
    assign o_vis_raddr = (r_state == ST_NB) ? i_col_rdata : r_v;
    assign o_fnd_raddr = (r_state == ST_IDLE) ? VW'(i_index) : r_ci[VW-1:0];
    assign o_fnd_waddr = r_ft[VW-1:0];
    assign o_fnd_wdata = (r_state == ST_NBW) ? r_u : r_v;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_INIT: begin
                if (init_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    unique case (t_req'(i_req_type)) inside
                        REQ_EXPAND: begin
                            if (qv_ok) begin
                                n_state = (r_ft == '0) ? ST_ROW0 : ST_CLR_RD;
                            end
                        end
                        REQ_READ:               n_state = ST_READ;
                        REQ_ROW_WR, REQ_COL_WR: n_state = ST_IDLE;
                        default:                n_state = ST_IDLE;
                    endcase
                end
            end
            ST_READ:   n_state = ST_IDLE;
            ST_CLR_RD: n_state = ST_CLR_WR;
            ST_CLR_WR: n_state = clr_last ? ST_ROW0 : ST_CLR_RD;
            ST_ROW0:   n_state = ST_ROW1;
            ST_ROW1:   n_state = ST_ROW2;
            ST_ROW2:   n_state = ST_COL;
            ST_COL: begin
                if (walk_end) begin
                    n_state = (r_level || i_hop_two) ? ST_OUT : ST_IDLE;
                end else begin
                    n_state = ST_NB;
                end
            end
            ST_NB:     n_state = nb_ok ? ST_NBW : ST_COL;
            ST_NBW:    n_state = ST_COL;
            ST_OUT:    n_state = outer_end ? ST_IDLE : ST_OUTNB;
            ST_OUTNB:  n_state = nb_ok ? ST_ROW0 : ST_OUT;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_ci        = r_ci;
        n_ft        = r_ft;
        n_strobe    = 1'b0;
        n_status    = r_status;
        n_fv        = r_fv;
        n_v         = r_v;
        n_u         = r_u;
        n_level     = r_level;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_e         = r_e;
        n_oe        = r_oe;
        n_ohi       = r_ohi;
        o_gctl      = '0;
        o_vctl      = '0;
        o_vis_waddr = r_v;
        unique case (r_state)
            ST_INIT: begin
                o_vctl.vis_we = 1'b1;
                o_vis_waddr   = r_ci[VW-1:0];
                n_ci          = r_ci + 1'b1;
            end
            ST_IDLE: begin
                if (accept) begin
                    unique case (t_req'(i_req_type))
                        REQ_ROW_WR: begin
                            o_gctl.row_we = row_ok;
                            n_strobe      = 1'b1;
                            n_status      = !row_ok;
                            n_fv          = '0;
                        end
                        REQ_COL_WR: begin
                            o_gctl.col_we = col_ok;
                            n_strobe      = 1'b1;
                            n_status      = !col_ok;
                            n_fv          = '0;
                        end
                        REQ_EXPAND: begin
                            n_status = !qv_ok;
                            n_fv     = '0;
                            n_strobe = !qv_ok;
                            n_v      = VW'(i_query_vertex);
                            n_level  = 1'b0;
                            n_ci     = '0;
                        end
                        REQ_READ: begin
                            n_status = !rd_ok;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_READ: begin
                n_strobe = 1'b1;
                n_fv     = r_status ? '0 : FV_W'(i_fnd_rdata);
            end
            ST_CLR_RD: begin
            end
            ST_CLR_WR: begin
                o_vctl.vis_we = 1'b1;
                o_vis_waddr   = i_fnd_rdata;
                n_ci          = r_ci + 1'b1;
                if (clr_last) begin
                    n_ft = '0;
                end
            end
            ST_ROW0: begin
            end
            ST_ROW1: begin
                n_lo = i_row_rdata;
                if (!i_vis_rdata && ft_room) begin
                    o_vctl.vis_we  = 1'b1;
                    o_vctl.vis_set = 1'b1;
                    o_vctl.fnd_we  = 1'b1;
                    n_ft           = r_ft + 1'b1;
                end
            end
            ST_ROW2: begin
                n_hi = (i_row_rdata < r_lo) ? r_lo : i_row_rdata;
                n_e  = r_lo;
            end
            ST_COL: begin
                if (walk_end) begin
                    if (!r_level && i_hop_two) begin
                        n_oe    = r_lo;
                        n_ohi   = r_hi;
                        n_level = 1'b1;
                    end else if (!r_level) begin
                        n_strobe = 1'b1;
                        n_status = 1'b0;
                        n_fv     = '0;
                    end
                end else begin
                    n_e = r_e + 1'b1;
                end
            end
            ST_NB: begin
                n_u = i_col_rdata;
            end
            ST_NBW: begin
                o_vis_waddr = r_u;
                if (!i_vis_rdata && ft_room) begin
                    o_vctl.vis_we  = 1'b1;
                    o_vctl.vis_set = 1'b1;
                    o_vctl.fnd_we  = 1'b1;
                    n_ft           = r_ft + 1'b1;
                end
            end
            ST_OUT: begin
                if (outer_end) begin
                    n_strobe = 1'b1;
                    n_status = 1'b0;
                    n_fv     = '0;
                end else begin
                    n_oe = r_oe + 1'b1;
                end
            end
            ST_OUTNB: begin
                n_v = i_col_rdata;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_INIT;
            r_ci     <= '0;
            r_ft     <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ci     <= n_ci;
            r_ft     <= n_ft;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_fv     <= n_fv;
        r_v      <= n_v;
        r_u      <= n_u;
        r_level  <= n_level;
        r_lo     <= n_lo;
        r_hi     <= n_hi;
        r_e      <= n_e;
        r_oe     <= n_oe;
        r_ohi    <= n_ohi;
    end

    assign o_busy         = r_state != ST_IDLE;
    assign o_strobe       = r_strobe;
    assign o_status       = r_status;
    assign o_found_vertex = r_fv;
    assign o_found_count  = FC_W'(r_ft);

    a_no_strobe_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> !r_strobe)
        else $error("result strobe while sequencer busy");

    a_found_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_ft) <= 32'(MAX_VERTICES))
        else $error("found count beyond capacity");

    a_found_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_vctl.fnd_we |-> (32'(r_ft) < 32'(MAX_VERTICES)))
        else $error("found list written when full");

    a_walk_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_COL) |-> (r_e <= r_hi))
        else $error("edge pointer passed row end");

    a_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_gctl.row_we || o_gctl.col_we) |-> (r_state == ST_IDLE) && i_start)
        else $error("graph write outside a request transfer");

endmodule

/* sv/csr_two_hop_neighborhood_unit.sv */
// Top level of the CSR two-hop neighbourhood expansion unit.
//
// Request channel: a request transfers on a rising edge with start high and
// busy low. Row-pointer and column writes answer in the cycle after the
// transfer; a read of the found list answers once it has passed the READ
// state; an out-of-range expand answers in the cycle after the transfer.
// An expand first clears the bitmap entries left by the previous query,
// then for each vertex expanded reads its row bounds, walks its column
// entries and checks each neighbour, and in two-hop mode walks the outer
// list. The sequencer and memories handle one request at a time.
// Each result is on o_status, o_found_vertex and o_found_count for the one
// cycle o_strobe is high; the receiver cannot stall it. A new request may
// transfer during that cycle.
// Configuration writes transfer on i_cfg_valid and o_cfg_ready while idle.
// After reset the visited bitmap is swept clear with busy high; the graph
// and found-list memories are not cleared.
module csr_two_hop_neighborhood_unit import cthn_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [REQ_W-1:0]   i_req_type,
    input  logic [INDEX_W-1:0] i_index,
    input  logic [VALUE_W-1:0] i_value,
    input  logic [QV_W-1:0]    i_query_vertex,
    output logic               o_strobe,
    output logic               o_status,
    output logic [FV_W-1:0]    o_found_vertex,
    output logic [FC_W-1:0]    o_found_count,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic               i_cfg_index,
    input  logic [VC_W-1:0]    i_cfg_data
);

    logic            r_hop_two;
    logic [VC_W-1:0] r_vertex_count;

    t_graph_ctl    gctl;
    t_visit_ctl    vctl;
    logic [RW-1:0] row_waddr;
    logic [EW-1:0] row_wdata;
    logic [RW-1:0] row_raddr;
    logic [EW-1:0] row_rdata;
    logic [CW-1:0] col_waddr;
    logic [VW-1:0] col_wdata;
    logic [CW-1:0] col_raddr;
    logic [VW-1:0] col_rdata;
    logic [VW-1:0] vis_raddr;
    logic [VW-1:0] vis_waddr;
    logic          vis_rdata;
    logic [VW-1:0] fnd_raddr;
    logic [VW-1:0] fnd_waddr;
    logic [VW-1:0] fnd_wdata;
    logic [VW-1:0] fnd_rdata;

    assign o_cfg_ready = !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hop_two      <= HOP_TWO_RESET;
            r_vertex_count <= VC_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_cfg_reg'(i_cfg_index))
                CFG_HOP_DEPTH:    r_hop_two      <= i_cfg_data[1];
                CFG_VERTEX_COUNT: r_vertex_count <= i_cfg_data;
                default:          r_hop_two      <= r_hop_two;
            endcase
        end
    end

    cthn_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .o_busy         (busy),
        .i_req_type     (i_req_type),
        .i_index        (i_index),
        .i_value        (i_value),
        .i_query_vertex (i_query_vertex),
        .i_hop_two      (r_hop_two),
        .i_vertex_count (r_vertex_count),
        .o_strobe       (o_strobe),
        .o_status       (o_status),
        .o_found_vertex (o_found_vertex),
        .o_found_count  (o_found_count),
        .o_gctl         (gctl),
        .o_row_waddr    (row_waddr),
        .o_row_wdata    (row_wdata),
        .o_row_raddr    (row_raddr),
        .i_row_rdata    (row_rdata),
        .o_col_waddr    (col_waddr),
        .o_col_wdata    (col_wdata),
        .o_col_raddr    (col_raddr),
        .i_col_rdata    (col_rdata),
        .o_vctl         (vctl),
        .o_vis_raddr    (vis_raddr),
        .o_vis_waddr    (vis_waddr),
        .i_vis_rdata    (vis_rdata),
        .o_fnd_raddr    (fnd_raddr),
        .o_fnd_waddr    (fnd_waddr),
        .o_fnd_wdata    (fnd_wdata),
        .i_fnd_rdata    (fnd_rdata)
    );

    cthn_graph_mem u_graph_mem (
        .i_clk       (i_clk),
        .i_ctl       (gctl),
        .i_row_waddr (row_waddr),
        .i_row_wdata (row_wdata),
        .i_row_raddr (row_raddr),
        .o_row_rdata (row_rdata),
        .i_col_waddr (col_waddr),
        .i_col_wdata (col_wdata),
        .i_col_raddr (col_raddr),
        .o_col_rdata (col_rdata)
    );

    cthn_visit_mem u_visit_mem (
        .i_clk       (i_clk),
        .i_ctl       (vctl),
        .i_vis_raddr (vis_raddr),
        .i_vis_waddr (vis_waddr),
        .o_vis_rdata (vis_rdata),
        .i_fnd_raddr (fnd_raddr),
        .i_fnd_waddr (fnd_waddr),
        .i_fnd_wdata (fnd_wdata),
        .o_fnd_rdata (fnd_rdata)
    );

endmodule
